FILE: rtl/irt_pkg.sv
`default_nettype none

package irt_pkg;

  // Defaults for the table sizes.
  localparam int unsigned NUM_CONTROLLERS_DEF = 8;
  localparam int unsigned NUM_OVERRIDES_DEF   = 16;

  // Request type codes.
  localparam logic [1:0] REQ_PROC  = 2'd0;
  localparam logic [1:0] REQ_CTRL  = 2'd1;
  localparam logic [1:0] REQ_OVR   = 2'd2;
  localparam logic [1:0] REQ_ROUTE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ROUTED = 2'd2;
  localparam logic [1:0] ST_NOCTL  = 2'd3;

  localparam logic [9:0] CPU_MAX   = 10'd1023;
  localparam logic [8:0] LINES_MAX = 9'd256;

  // MPS flag field value that selects active low or level trigger.
  localparam logic [1:0] MPS_ASSERTED = 2'b11;

  // Bit positions in the low redirection word.
  localparam int unsigned LOW_ACTIVE_LOW_BIT = 13;
  localparam int unsigned LOW_LEVEL_BIT      = 15;
  localparam int unsigned APIC_ID_SHIFT      = 24;

  // Table entry layouts.
  localparam int unsigned OVR_W = 8 + 32 + 4;
  localparam int unsigned CTL_W = 32 + 9;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OVR  = 4'b0010,
    S_CTL  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/irt_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module irt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/isa_irq_route_table.sv
`default_nettype none

// ISA IRQ routing table. The block takes decoded interrupt-table records and
// route requests as transactions on a valid/ready input channel and returns
// exactly one result transaction per input on a valid/ready output channel.
// Processor, controller and override records pass from acceptance through the
// result state into the output register; the next input is taken once the
// result state has handed its result over. A route request scans the override
// table and then the controller table, one entry per cycle through the single
// read port of each table RAM; the controller scan stops at the first
// controller whose range holds the GSI.
// One transaction is worked on at a time; a finished result sits in the output
// register, so the next input is taken while that result waits. The tables
// need no clearing after reset: scans never look past the fill counts, so an
// entry is only read after it has been written. Users must write dest_apic_id
// via cfg_we_i/cfg_wdata_i only while idle; the block does not enforce this.
module isa_irq_route_table
  import irt_pkg::*;
#(
  parameter int unsigned NUM_CONTROLLERS = NUM_CONTROLLERS_DEF,
  parameter int unsigned NUM_OVERRIDES   = NUM_OVERRIDES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [1:0]  proc_flags_i,
  input  wire logic [31:0] first_gsi_i,
  input  wire logic [8:0]  line_count_i,
  input  wire logic [7:0]  src_irq_i,
  input  wire logic [31:0] target_gsi_i,
  input  wire logic [3:0]  mps_flags_i,
  input  wire logic [7:0]  vector_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [2:0]       controller_index_o,
  output logic [7:0]       entry_index_o,
  output logic [31:0]      low_word_o,
  output logic [31:0]      high_word_o,
  output logic [31:0]      resolved_gsi_o,
  output logic [9:0]       cpu_total_o
);

  localparam int unsigned OAW = (NUM_OVERRIDES > 1) ? $clog2(NUM_OVERRIDES) : 1;
  localparam int unsigned CAW = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
  localparam int unsigned OCW = $clog2(NUM_OVERRIDES + 1);
  localparam int unsigned CCW = $clog2(NUM_CONTROLLERS + 1);

  state_e state_q, state_d;

  logic [9:0]     cpu_q, cpu_d;
  logic [7:0]     apic_q;
  logic [OCW-1:0] ovr_used_q, ovr_used_d;
  logic [CCW-1:0] ctl_used_q, ctl_used_d;
  logic [OCW-1:0] ovr_idx_q, ovr_idx_d;
  logic [CCW-1:0] ctl_idx_q, ctl_idx_d;
  logic [CCW-1:0] dat_idx_q, dat_idx_d;
  logic           dv_q, dv_d;

  // Working registers of the transaction in flight.
  logic [7:0]  irq_q, irq_d;
  logic [7:0]  vec_q, vec_d;
  logic [31:0] gsi_q, gsi_d;
  logic        alow_q, alow_d;
  logic        level_q, level_d;
  logic [1:0]  st_q, st_d;
  logic [2:0]  hit_idx_q, hit_idx_d;
  logic [7:0]  entry_q, entry_d;

  logic        out_valid_q;
  logic        out_load;
  logic        accept;

  // Table RAM ports.
  logic             ovr_we;
  logic [OVR_W-1:0] ovr_wdata, ovr_rdata;
  logic             ctl_we;
  logic [CTL_W-1:0] ctl_wdata, ctl_rdata;
  logic [8:0]       lines_clamped;

  // Fields of the entries just read.
  logic [7:0]  rd_irq;
  logic [31:0] rd_ogsi;
  logic [3:0]  rd_flags;
  logic [31:0] rd_base;
  logic [8:0]  rd_lines;
  logic [32:0] rd_top;
  logic [31:0] rd_off;
  logic        ctl_hit;
  logic        ovr_issue;
  logic        ctl_issue;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign lines_clamped = (line_count_i > LINES_MAX) ? LINES_MAX : line_count_i;
  assign ovr_wdata     = {src_irq_i, target_gsi_i, mps_flags_i};
  assign ctl_wdata     = {first_gsi_i, lines_clamped};
  assign ovr_we = accept && (req_type_i == REQ_OVR) && (ovr_used_q < OCW'(NUM_OVERRIDES));
  assign ctl_we = accept && (req_type_i == REQ_CTRL) && (ctl_used_q < CCW'(NUM_CONTROLLERS));

  irt_ram #(
    .WIDTH (OVR_W),
    .DEPTH (NUM_OVERRIDES)
  ) u_ovr_ram (
    .clk_i   (clk_i),
    .we_i    (ovr_we),
    .waddr_i (ovr_used_q[OAW-1:0]),
    .wdata_i (ovr_wdata),
    .raddr_i (ovr_idx_q[OAW-1:0]),
    .rdata_o (ovr_rdata)
  );

  irt_ram #(
    .WIDTH (CTL_W),
    .DEPTH (NUM_CONTROLLERS)
  ) u_ctl_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_we),
    .waddr_i (ctl_used_q[CAW-1:0]),
    .wdata_i (ctl_wdata),
    .raddr_i (ctl_idx_q[CAW-1:0]),
    .rdata_o (ctl_rdata)
  );

  assign rd_irq   = ovr_rdata[43:36];
  assign rd_ogsi  = ovr_rdata[35:4];
  assign rd_flags = ovr_rdata[3:0];
  assign rd_base  = ctl_rdata[40:9];
  assign rd_lines = ctl_rdata[8:0];
  // The top of the range is formed in 33 bits so that it never wraps.
  assign rd_top   = {1'b0, rd_base} + 33'(rd_lines);
  assign rd_off   = gsi_q - rd_base;
  assign ctl_hit  = (gsi_q >= rd_base) && ({1'b0, gsi_q} < rd_top);

  assign ovr_issue = (ovr_idx_q < ovr_used_q);
  assign ctl_issue = (ctl_idx_q < ctl_used_q);

  always_comb begin
    state_d    = state_q;
    cpu_d      = cpu_q;
    ovr_used_d = ovr_used_q;
    ctl_used_d = ctl_used_q;
    ovr_idx_d  = ovr_idx_q;
    ctl_idx_d  = ctl_idx_q;
    dat_idx_d  = dat_idx_q;
    dv_d       = dv_q;
    irq_d      = irq_q;
    vec_d      = vec_q;
    gsi_d      = gsi_q;
    alow_d     = alow_q;
    level_d    = level_q;
    st_d       = st_q;
    hit_idx_d  = hit_idx_q;
    entry_d    = entry_q;
    out_load   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          irq_d     = src_irq_i;
          vec_d     = vector_i;
          gsi_d     = '0;
          alow_d    = 1'b0;
          level_d   = 1'b0;
          hit_idx_d = '0;
          entry_d   = '0;
          st_d      = ST_OK;
          dv_d      = 1'b0;
          state_d   = S_DONE;
          unique case (req_type_i)
            REQ_PROC: begin
              if ((proc_flags_i != 2'b00) && (cpu_q != CPU_MAX)) begin
                cpu_d = cpu_q + 10'd1;
              end
            end
            REQ_CTRL: begin
              if (ctl_we) begin
                ctl_used_d = ctl_used_q + CCW'(1);
              end else begin
                st_d = ST_FULL;
              end
            end
            REQ_OVR: begin
              if (ovr_we) begin
                ovr_used_d = ovr_used_q + OCW'(1);
              end else begin
                st_d = ST_FULL;
              end
            end
            REQ_ROUTE: begin
              gsi_d     = {24'd0, src_irq_i};
              st_d      = ST_NOCTL;
              ovr_idx_d = '0;
              state_d   = S_OVR;
            end
            default: begin
              st_d = ST_OK;
            end
          endcase
        end
      end

      S_OVR: begin
        // Reads are issued one entry ahead of the compare.
        if (ovr_issue) begin
          ovr_idx_d = ovr_idx_q + OCW'(1);
          dv_d      = 1'b1;
        end else begin
          dv_d = 1'b0;
        end
        if (dv_q && (rd_irq == irq_q)) begin
          gsi_d = rd_ogsi;
          if (rd_flags[1:0] == MPS_ASSERTED) begin
            alow_d = 1'b1;
          end
          if (rd_flags[3:2] == MPS_ASSERTED) begin
            level_d = 1'b1;
          end
        end
        if (!ovr_issue && !dv_q) begin
          ctl_idx_d = '0;
          state_d   = S_CTL;
        end
      end

      S_CTL: begin
        if (ctl_issue) begin
          ctl_idx_d = ctl_idx_q + CCW'(1);
          dat_idx_d = ctl_idx_q;
          dv_d      = 1'b1;
        end else begin
          dv_d = 1'b0;
        end
        if (dv_q && ctl_hit) begin
          // The first controller that holds the GSI wins.
          st_d      = ST_ROUTED;
          hit_idx_d = 3'(dat_idx_q);
          entry_d   = rd_off[7:0];
          dv_d      = 1'b0;
          state_d   = S_DONE;
        end else if (!ctl_issue && !dv_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cpu_q       <= '0;
      apic_q      <= '0;
      ovr_used_q  <= '0;
      ctl_used_q  <= '0;
      ovr_idx_q   <= '0;
      ctl_idx_q   <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cpu_q      <= cpu_d;
      ovr_used_q <= ovr_used_d;
      ctl_used_q <= ctl_used_d;
      ovr_idx_q  <= ovr_idx_d;
      ctl_idx_q  <= ctl_idx_d;
      dv_q       <= dv_d;
      if (cfg_we_i) begin
        apic_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dat_idx_q <= dat_idx_d;
    irq_q     <= irq_d;
    vec_q     <= vec_d;
    gsi_q     <= gsi_d;
    alow_q    <= alow_d;
    level_q   <= level_d;
    st_q      <= st_d;
    hit_idx_q <= hit_idx_d;
    entry_q   <= entry_d;
    if (out_load) begin
      status_o           <= st_q;
      resolved_gsi_o     <= gsi_q;
      cpu_total_o        <= cpu_q;
      controller_index_o <= hit_idx_q;
      entry_index_o      <= entry_q;
      if (st_q == ST_ROUTED) begin
        low_word_o <= {16'd0, level_q, 1'b0, alow_q, 5'd0, vec_q};
        high_word_o <= {apic_q, 24'd0};
      end else begin
        low_word_o  <= '0;
        high_word_o <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // The CPU count only ever steps up by one.
  a_cpu_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cpu_q != $past(cpu_q)) |-> (cpu_q == $past(cpu_q) + 10'd1))
    else $error("cpu count changed by other than one");

  // Fill counts never pass the table sizes.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovr_used_q <= OCW'(NUM_OVERRIDES)) && (ctl_used_q <= CCW'(NUM_CONTROLLERS)))
    else $error("table fill count out of range");

  // A result only appears after the result state handed it over.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result valid without a finished transaction");

  // Accepted input leaves the idle state, so no second input is taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("input accepted but block stayed idle");

endmodule

`default_nettype wire

FILE: tb/isa_irq_route_table_tb.sv
module isa_irq_route_table_tb
  import irt_pkg::*;
;

  // Table sizes of the instance; the scoreboard copy of the tables uses the same.
  localparam int NCTL = NUM_CONTROLLERS_DEF;
  localparam int NOVR = NUM_OVERRIDES_DEF;

  // A stuck run ends here.
  localparam int CYCLE_LIMIT = 400000;
  // Bound on waiting for outstanding results, and the quiet tail at the end.
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  // Length of the deliberate receiver hold-off that backs up the block.
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;
  localparam int DIR_N       = 24;

  // One input transaction, at the widths of the ports.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  proc_flags;
    logic [31:0] first_gsi;
    logic [8:0]  line_count;
    logic [7:0]  src_irq;
    logic [31:0] target_gsi;
    logic [3:0]  mps_flags;
    logic [7:0]  vector;
  } irq_req_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  controller_index;
    logic [7:0]  entry_index;
    logic [31:0] low_word;
    logic [31:0] high_word;
    logic [31:0] resolved_gsi;
    logic [9:0]  cpu_total;
  } route_res_t;

  // A row of the directed table. Where typed is set, the expected status, GSI
  // and CPU count are written in the row and every other result field is zero.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  proc_flags;
    logic [31:0] first_gsi;
    logic [8:0]  line_count;
    logic [7:0]  src_irq;
    logic [31:0] target_gsi;
    logic [3:0]  mps_flags;
    logic [7:0]  vector;
    logic        typed;
    logic [1:0]  status;
    logic [31:0] resolved_gsi;
    logic [9:0]  cpu_total;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  irq_req_t    req_drv = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [2:0]  controller_index;
  logic [7:0]  entry_index;
  logic [31:0] low_word;
  logic [31:0] high_word;
  logic [31:0] resolved_gsi;
  logic [9:0]  cpu_total;

  always #2 clk = ~clk;

  isa_irq_route_table #(
    .NUM_CONTROLLERS(NCTL),
    .NUM_OVERRIDES  (NOVR)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .req_type_i        (req_drv.req_type),
    .proc_flags_i      (req_drv.proc_flags),
    .first_gsi_i       (req_drv.first_gsi),
    .line_count_i      (req_drv.line_count),
    .src_irq_i         (req_drv.src_irq),
    .target_gsi_i      (req_drv.target_gsi),
    .mps_flags_i       (req_drv.mps_flags),
    .vector_i          (req_drv.vector),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (status),
    .controller_index_o(controller_index),
    .entry_index_o     (entry_index),
    .low_word_o        (low_word),
    .high_word_o       (high_word),
    .resolved_gsi_o    (resolved_gsi),
    .cpu_total_o       (cpu_total)
  );

  // ---------------------------------------------------------------------------
  // Scoreboard copy of the routing tables and of the destination register.
  // The state is updated in the order in which input transactions are taken,
  // which is also the order in which the block returns its results.
  // ---------------------------------------------------------------------------
  logic [9:0]  cpu_seen = '0;
  logic [31:0] ctl_base [NCTL];
  logic [8:0]  ctl_lines [NCTL];
  int          ctl_fill = 0;
  logic [7:0]  ovr_irq [NOVR];
  logic [31:0] ovr_gsi [NOVR];
  logic [3:0]  ovr_mps [NOVR];
  int          ovr_fill = 0;
  logic [7:0]  dest_id = 8'd0;

  route_res_t  route_q [$];
  route_res_t  exp_res;
  route_res_t  got_res;
  int          err_cnt = 0;
  int          burst_left = 0;
  logic        hold_req = 1'b0;

  // Applies one record or route request to the table copy and returns the
  // result that the block has to give for it.
  function automatic route_res_t resolve_route(input irq_req_t rq);
    route_res_t  res;
    logic [31:0] gsi;
    logic [31:0] sense;
    logic [32:0] top;
    logic        hit;
    res = '0;
    case (rq.req_type)
      REQ_PROC: begin
        // Either flag bit counts the processor; the count sticks at its maximum.
        if (rq.proc_flags != 2'b00 && cpu_seen < CPU_MAX) cpu_seen = cpu_seen + 10'd1;
      end
      REQ_CTRL: begin
        if (ctl_fill < NCTL) begin
          ctl_base[ctl_fill]  = rq.first_gsi;
          ctl_lines[ctl_fill] = (rq.line_count > LINES_MAX) ? LINES_MAX : rq.line_count;
          ctl_fill++;
        end else begin
          res.status = ST_FULL;
        end
      end
      REQ_OVR: begin
        if (ovr_fill < NOVR) begin
          ovr_irq[ovr_fill] = rq.src_irq;
          ovr_gsi[ovr_fill] = rq.target_gsi;
          ovr_mps[ovr_fill] = rq.mps_flags;
          ovr_fill++;
        end else begin
          res.status = ST_FULL;
        end
      end
      default: begin
        // The last matching override names the GSI, while the sense bits
        // collect over every match.
        gsi   = {24'd0, rq.src_irq};
        sense = '0;
        for (int i = 0; i < ovr_fill; i++) begin
          if (ovr_irq[i] == rq.src_irq) begin
            gsi = ovr_gsi[i];
            if (ovr_mps[i][1:0] == MPS_ASSERTED) sense[LOW_ACTIVE_LOW_BIT] = 1'b1;
            if (ovr_mps[i][3:2] == MPS_ASSERTED) sense[LOW_LEVEL_BIT] = 1'b1;
          end
        end
        res.resolved_gsi = gsi;
        res.status       = ST_NOCTL;
        hit              = 1'b0;
        // First controller wins. The range end is 33 bits wide, so a window
        // at the top of the GSI space still covers 0xFFFFFFFF.
        for (int i = 0; i < ctl_fill; i++) begin
          top = {1'b0, ctl_base[i]} + {24'd0, ctl_lines[i]};
          if (!hit && gsi >= ctl_base[i] && {1'b0, gsi} < top) begin
            hit                  = 1'b1;
            res.status           = ST_ROUTED;
            res.controller_index = i[2:0];
            res.entry_index      = 8'(gsi - ctl_base[i]);
            res.low_word         = {24'd0, rq.vector} | sense;
            res.high_word        = {24'd0, dest_id} << APIC_ID_SHIFT;
          end
        end
      end
    endcase
    res.cpu_total = cpu_seen;
    return res;
  endfunction

  // Random input transaction. Every data field starts out fully random, so that
  // the fields the block ignores for a given type also see all their bits;
  // the fields that matter are then steered toward values that hit the tables.
  function automatic irq_req_t make_random_request();
    irq_req_t rq;
    int       sel;
    rq.proc_flags = 2'($urandom);
    rq.first_gsi  = $urandom;
    rq.line_count = 9'($urandom);
    rq.src_irq    = 8'($urandom);
    rq.target_gsi = $urandom;
    rq.mps_flags  = 4'($urandom);
    rq.vector     = 8'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      rq.req_type = REQ_PROC;
    end else if (sel < 20) begin
      rq.req_type = REQ_CTRL;
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          rq.first_gsi  = 32'(24 * $urandom_range(1, 9));
          rq.line_count = 9'd24;
        end
        3: rq.first_gsi = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
        4: begin
          rq.first_gsi  = 32'($urandom_range(0, 255));
          rq.line_count = 9'($urandom_range(0, 40));
        end
        default: ;
      endcase
    end else if (sel < 27) begin
      rq.req_type = REQ_OVR;
      if ($urandom_range(0, 4) != 0) rq.src_irq = 8'($urandom_range(0, 15));
      case ($urandom_range(0, 4))
        0, 1: rq.target_gsi = 32'($urandom_range(0, 255));
        2:    rq.target_gsi = 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
        3:    rq.target_gsi = {24'd0, rq.src_irq};
        default: ;
      endcase
    end else begin
      rq.req_type = REQ_ROUTE;
      if ($urandom_range(0, 3) != 0) rq.src_irq = 8'($urandom_range(0, 31));
    end
    return rq;
  endfunction

  task automatic report_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // Offers one input transaction and holds it until the block takes it. The
  // sender works in bursts; a new burst may start after a gap with valid low.
  task automatic send_request(input irq_req_t rq, input logic typed, input route_res_t typed_res);
    int         gap;
    route_res_t res;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_drv  <= rq;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    // The table copy moves on even where the row gives the result by hand.
    res = resolve_route(rq);
    route_q.push_back(typed ? typed_res : res);
  endtask

  // Lowers valid, waits up to the drain bound for every result. Each transaction
  // gives exactly one result, so an empty queue also means the block is idle.
  task automatic wait_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (route_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic write_dest_apic(input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we  <= 1'b0;
    dest_id  = value;
  endtask

  task automatic run_random_phase(input int n_items);
    for (int k = 0; k < n_items; k++) send_request(make_random_request(), 1'b0, '0);
  endtask

  // Directed table. It starts on empty tables, walks every record type and
  // both flag bits of a processor record, stores controllers with a clipped
  // line count, an empty range and a window at the very top of the GSI space,
  // and then routes through repeated overrides of one IRQ, through an override
  // whose polarity code is not the asserted one, and onto range edges.
  dir_row_t dir_tbl [DIR_N] = '{
    '{REQ_ROUTE, 2'd0, 32'h0, 9'd0, 8'd5, 32'h0, 4'h0, 8'h30, 1'b1, ST_NOCTL, 32'd5, 10'd0},
    '{REQ_PROC, 2'd0, 32'h0, 9'd0, 8'd0, 32'h0, 4'h0, 8'h00, 1'b1, ST_OK, 32'd0, 10'd0},
    '{REQ_PROC, 2'd1, 32'h0, 9'd0, 8'd0, 32'h0, 4'h0, 8'h00, 1'b1, ST_OK, 32'd0, 10'd1},
    '{REQ_PROC, 2'd2, 32'h0, 9'd0, 8'd0, 32'h0, 4'h0, 8'h00, 1'b1, ST_OK, 32'd0, 10'd2},
    '{REQ_PROC, 2'd3, 32'h0, 9'd0, 8'd0, 32'h0, 4'h0, 8'h00, 1'b1, ST_OK, 32'd0, 10'd3},
    '{REQ_CTRL, 2'd0, 32'h0, 9'd24, 8'd0, 32'h0, 4'h0, 8'h00, 1'b1, ST_OK, 32'd0, 10'd3},
    '{REQ_CTRL, 2'd0, 32'hFFFF_FF00, 9'd511, 8'd0, 32'h0, 4'h0, 8'h00,
      1'b1, ST_OK, 32'd0, 10'd3},
    '{REQ_CTRL, 2'd0, 32'd100, 9'd0, 8'd0, 32'h0, 4'h0, 8'h00, 1'b1, ST_OK, 32'd0, 10'd3},
    '{REQ_ROUTE, 2'd0, 32'h0, 9'd0, 8'd3, 32'h0, 4'h0, 8'hFF, 1'b0, ST_OK, 32'd0, 10'd0},
    '{REQ_ROUTE, 2'd0, 32'h0, 9'd0, 8'hFF, 32'h0, 4'h0, 8'h00,
      1'b1, ST_NOCTL, 32'd255, 10'd3},
    '{REQ_OVR, 2'd0, 32'h0, 9'd0, 8'd9, 32'd100, 4'hC, 8'h00, 1'b1, ST_OK, 32'd0, 10'd3},
    '{REQ_OVR, 2'd0, 32'h0, 9'd0, 8'd9, 32'hFFFF_FFFF, 4'h3, 8'h00,
      1'b1, ST_OK, 32'd0, 10'd3},
    '{REQ_OVR, 2'd0, 32'h0, 9'd0, 8'd0, 32'd2, 4'h0, 8'h00, 1'b1, ST_OK, 32'd0, 10'd3},
    '{REQ_OVR, 2'd0, 32'h0, 9'd0, 8'd7, 32'd101, 4'h1, 8'h00, 1'b1, ST_OK, 32'd0, 10'd3},
    '{REQ_ROUTE, 2'd0, 32'h0, 9'd0, 8'd9, 32'h0, 4'h0, 8'h41, 1'b0, ST_OK, 32'd0, 10'd0},
    '{REQ_ROUTE, 2'd0, 32'h0, 9'd0, 8'd0, 32'h0, 4'h0, 8'h00, 1'b0, ST_OK, 32'd0, 10'd0},
    '{REQ_ROUTE, 2'd0, 32'h0, 9'd0, 8'd2, 32'h0, 4'h0, 8'h80, 1'b0, ST_OK, 32'd0, 10'd0},
    '{REQ_ROUTE, 2'd0, 32'h0, 9'd0, 8'd7, 32'h0, 4'h0, 8'h12,
      1'b1, ST_NOCTL, 32'd101, 10'd3},
    '{REQ_CTRL, 2'd0, 32'd101, 9'd1, 8'd0, 32'h0, 4'h0, 8'h00, 1'b1, ST_OK, 32'd0, 10'd3},
    '{REQ_ROUTE, 2'd0, 32'h0, 9'd0, 8'd7, 32'h0, 4'h0, 8'h12, 1'b0, ST_OK, 32'd0, 10'd0},
    '{REQ_PROC, 2'd0, 32'hFFFF_FFFF, 9'h1FF, 8'hFF, 32'hFFFF_FFFF, 4'hF, 8'hFF,
      1'b1, ST_OK, 32'd0, 10'd3},
    '{REQ_ROUTE, 2'd0, 32'h0, 9'd0, 8'd23, 32'h0, 4'h0, 8'h7F, 1'b0, ST_OK, 32'd0, 10'd0},
    '{REQ_ROUTE, 2'd0, 32'h0, 9'd0, 8'd24, 32'h0, 4'h0, 8'h01,
      1'b1, ST_NOCTL, 32'd24, 10'd3},
    '{REQ_CTRL, 2'd0, 32'hFFFF_FFFF, 9'd256, 8'd0, 32'h0, 4'h0, 8'h00,
      1'b1, ST_OK, 32'd0, 10'd3}
  };

  // ---------------------------------------------------------------------------
  // Result checker. Every accepted result transaction is compared with the
  // oldest expectation; a result with nothing waiting is an error as well.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_res = '{status, controller_index, entry_index, low_word, high_word,
                  resolved_gsi, cpu_total};
      if (route_q.size() == 0) begin
        report_error($sformatf("unexpected result: st=%0d gsi=%h", status, resolved_gsi));
      end else begin
        exp_res = route_q.pop_front();
        if (got_res.status != exp_res.status ||
            got_res.controller_index != exp_res.controller_index ||
            got_res.entry_index != exp_res.entry_index ||
            got_res.low_word != exp_res.low_word ||
            got_res.high_word != exp_res.high_word ||
            got_res.resolved_gsi != exp_res.resolved_gsi ||
            got_res.cpu_total != exp_res.cpu_total) begin
          report_error({
            $sformatf("mismatch: exp st=%0d ctl=%0d ent=%0d lo=%h hi=%h gsi=%h cpu=%0d",
                      exp_res.status, exp_res.controller_index, exp_res.entry_index,
                      exp_res.low_word, exp_res.high_word, exp_res.resolved_gsi,
                      exp_res.cpu_total),
            $sformatf(" / got st=%0d ctl=%0d ent=%0d lo=%h hi=%h gsi=%h cpu=%0d",
                      got_res.status, got_res.controller_index, got_res.entry_index,
                      got_res.low_word, got_res.high_word, got_res.resolved_gsi,
                      got_res.cpu_total)});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It switches at random between stall patterns:
  // always ready, coin flip, mostly stalled, and a fixed duty cycle. When the
  // main sequence asks for it, ready stays low for a long stretch so that the
  // output register and the working slot fill and the block stalls its input.
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int phase_cnt;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    phase_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(40, 150);
      end
      mode_left--;
      phase_cnt++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((phase_cnt % 7) < 4);
        endcase
      end
    end
  end

  // Cycle limit. A hung handshake ends the run here.
  initial begin
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("isa_irq_route_table regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, the directed table, five random phases under
  // different destination ids (both extremes among them), and the final drain.
  // ---------------------------------------------------------------------------
  initial begin
    irq_req_t   rq;
    route_res_t typed_res;
    logic [7:0] apic_ids [5];
    apic_ids = '{8'hFF, 8'h00, 8'h5A, 8'h80, 8'h01};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows. Typed rows carry their result; the rest go to the model.
    for (int r = 0; r < DIR_N; r++) begin
      rq = '{dir_tbl[r].req_type, dir_tbl[r].proc_flags, dir_tbl[r].first_gsi,
             dir_tbl[r].line_count, dir_tbl[r].src_irq, dir_tbl[r].target_gsi,
             dir_tbl[r].mps_flags, dir_tbl[r].vector};
      typed_res              = '0;
      typed_res.status       = dir_tbl[r].status;
      typed_res.resolved_gsi = dir_tbl[r].resolved_gsi;
      typed_res.cpu_total    = dir_tbl[r].cpu_total;
      send_request(rq, dir_tbl[r].typed, typed_res);
    end
    wait_drained();

    // Random phases. The destination id is only rewritten once the block
    // has returned every result, and the third phase also carries a random id.
    // The long receiver hold-off falls into the second phase.
    for (int p = 0; p < 5; p++) begin
      write_dest_apic((p == 2) ? 8'($urandom) : apic_ids[p]);
      if (p == 1) hold_req = 1'b1;
      run_random_phase(PHASE_ITEMS);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (route_q.size() != 0)
      report_error($sformatf("%0d results never arrived", route_q.size()));

    if (err_cnt == 0) begin
      $display("isa_irq_route_table regression: pass");
    end else begin
      $display("isa_irq_route_table regression: fail");
    end
    $finish;
  end

endmodule
